FILE: rtl/core/jqps_pkg.sv
// ----------------------------------------------------------------------------
// jqps_pkg: shared types and constants for the priority-sorted job queue
// Holds the entry layout, the request codes and the fixed field widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jqps_pkg;

  localparam int PRIO_W  = 16;
  localparam int ID_W    = 32;
  localparam int COUNT_W = 5;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_FINISH = 2'd1;
  localparam logic [1:0] ACT_SORT   = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic        [ID_W-1:0]   id;
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/jqps_entry_ram.sv
// ----------------------------------------------------------------------------
// jqps_entry_ram: job table storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jqps_entry_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire jqps_pkg::entry_t wr_data,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output jqps_pkg::entry_t     rd_data
);
  import jqps_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/jqps_order_cmp.sv
// ----------------------------------------------------------------------------
// jqps_order_cmp: queue ordering compare
// True when job a belongs ahead of job b: higher priority first, then
// lower id.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jqps_order_cmp (
  input  wire jqps_pkg::entry_t a,
  input  wire jqps_pkg::entry_t b,
  output logic                  a_first
);
  import jqps_pkg::*;

  always_comb begin
    if (a.prio != b.prio) begin
      a_first = ($signed(a.prio) > $signed(b.prio));
    end else begin
      a_first = (a.id < b.id);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/job_queue_priority_sort_top.sv
// Sequence, transfer to result: add and clear go straight to the front read;
//   finish first shifts each later job down one slot (read, then write); sort
//   runs bubble passes over the single table read port, shrinking by one each.
// Throughput: one request in flight; the next transfer is taken once the
//   sequencer is back in idle, even while the last result waits downstream.
// Reset: job count and id counter clear; table contents stay undefined.
// ----------------------------------------------------------------------------
// job_queue_priority_sort_top: bounded job queue with in-place sort
// Sequencer over a job table memory and one shared order compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module job_queue_priority_sort_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   action,
  input  wire logic signed [jqps_pkg::PRIO_W-1:0] priority_req,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [jqps_pkg::COUNT_W-1:0]      job_count,
  output logic                              front_valid,
  output logic signed [jqps_pkg::PRIO_W-1:0] front_priority,
  output logic [jqps_pkg::ID_W-1:0]         front_id,
  output logic                              add_dropped
);
  import jqps_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PASS_LD,
    S_PASS_HEAD,
    S_PASS_RD,
    S_PASS_CMP,
    S_PASS_END,
    S_FRONT_RD,
    S_FRONT_WR
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [ID_W-1:0] next_id;
  logic [AW-1:0]   idx;
  logic [AW-1:0]   lim;
  entry_t          carry;
  logic            dropped;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  entry_t          wr_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  entry_t          rd_data;
  logic            rd_first;
  logic            full;
  logic            accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign full     = (count == CW'(QUEUE_DEPTH));

  jqps_entry_ram #(
    .DEPTH(QUEUE_DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  jqps_order_cmp u_cmp (
    .a      (rd_data),
    .b      (carry),
    .a_first(rd_first)
  );

  always_comb begin
    rd_en   = (state == S_SHIFT_RD) || (state == S_PASS_LD) ||
              (state == S_PASS_RD) || (state == S_FRONT_RD);
    rd_addr = ((state == S_PASS_LD) || (state == S_FRONT_RD)) ? '0 : idx;
    wr_en   = 1'b0;
    wr_addr = idx - 1'b1;
    wr_data = rd_data;
    unique case (state)
      S_IDLE: begin
        wr_en        = accept && (action == ACT_ADD) && !full;
        wr_addr      = count[AW-1:0];
        wr_data.prio = priority_req;
        wr_data.id   = next_id;
      end
      S_SHIFT_WR: begin
        wr_en = 1'b1;
      end
      S_PASS_CMP: begin
        // the one of the pair that belongs later keeps bubbling toward the tail
        wr_en   = 1'b1;
        wr_data = rd_first ? rd_data : carry;
      end
      S_PASS_END: begin
        wr_en   = 1'b1;
        wr_addr = lim;
        wr_data = carry;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      next_id   <= '0;
      out_valid <= 1'b0;
    end else begin
      // the result state sets valid itself when the register frees up
      if (out_valid && !out_stall && (state != S_FRONT_WR)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            dropped <= 1'b0;
            state   <= S_FRONT_RD;
            unique case (action)
              ACT_ADD: begin
                if (full) begin
                  dropped <= 1'b1;
                end else begin
                  count   <= count + 1'b1;
                  next_id <= next_id + 1'b1;
                end
              end
              ACT_FINISH: begin
                if (count > CW'(1)) begin
                  idx   <= AW'(1);
                  state <= S_SHIFT_RD;
                end else begin
                  count <= '0;
                end
              end
              ACT_SORT: begin
                if (count > CW'(1)) begin
                  lim   <= AW'(count - 1'b1);
                  state <= S_PASS_LD;
                end
              end
              ACT_CLEAR: begin
                count <= '0;
              end
            endcase
          end
        end
        S_SHIFT_RD: begin
          state <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          if (idx == AW'(count - 1'b1)) begin
            count <= count - 1'b1;
            state <= S_FRONT_RD;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SHIFT_RD;
          end
        end
        S_PASS_LD: begin
          state <= S_PASS_HEAD;
        end
        S_PASS_HEAD: begin
          carry <= rd_data;
          idx   <= AW'(1);
          state <= S_PASS_RD;
        end
        S_PASS_RD: begin
          state <= S_PASS_CMP;
        end
        S_PASS_CMP: begin
          if (!rd_first) begin
            carry <= rd_data;
          end
          if (idx == lim) begin
            state <= S_PASS_END;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_PASS_RD;
          end
        end
        S_PASS_END: begin
          if (lim == AW'(1)) begin
            state <= S_FRONT_RD;
          end else begin
            lim   <= lim - 1'b1;
            state <= S_PASS_LD;
          end
        end
        S_FRONT_RD: begin
          state <= S_FRONT_WR;
        end
        S_FRONT_WR: begin
          // hold here until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            job_count      <= COUNT_W'(count);
            front_valid    <= (count != '0);
            front_priority <= (count != '0) ? rd_data.prio : '0;
            front_id       <= (count != '0) ? rd_data.id : '0;
            add_dropped    <= dropped;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: verif/tb_job_queue_priority_sort_top.sv
// ----------------------------------------------------------------------------
// tb_job_queue_priority_sort_top: self-checking bench for the sorted job queue
// A directed opening pass and random request batches feed a negedge driver.
// A posedge monitor mirrors the queue in place, predicts each result and
// checks it field by field against the block's output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_job_queue_priority_sort_top;
  import jqps_pkg::*;

  localparam int QDEPTH      = 16;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int REQ_TARGET  = 1120;
  // longest request is a full-table sort
  localparam int DRAIN_WAIT  = 320;

  typedef struct {
    logic [1:0]               act;
    logic signed [PRIO_W-1:0] prio;
  } job_req_t;

  typedef struct {
    logic [COUNT_W-1:0]       count;
    logic                     valid;
    logic signed [PRIO_W-1:0] prio;
    logic [ID_W-1:0]          id;
    logic                     dropped;
  } queue_view_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [1:0] action = ACT_ADD;
  logic signed [PRIO_W-1:0] priority_req = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [COUNT_W-1:0] job_count;
  logic front_valid;
  logic signed [PRIO_W-1:0] front_priority;
  logic [ID_W-1:0] front_id;
  logic add_dropped;

  job_req_t    pending_reqs[$];
  queue_view_t expected_views[$];

  // mirror of the job table
  entry_t          mirror_tab[QDEPTH];
  int              mirror_count = 0;
  logic [ID_W-1:0] mirror_next_id = '0;

  logic in_taken = 1'b0;
  int send_gap = 0;
  int send_calm = 0;
  int recv_wait = 0;
  int recv_calm = 0;
  int cycle_count = 0;
  int error_count = 0;
  job_req_t next_req;
  queue_view_t want;

  job_queue_priority_sort_top #(
    .QUEUE_DEPTH(QDEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .priority_req(priority_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .job_count(job_count),
    .front_valid(front_valid),
    .front_priority(front_priority),
    .front_id(front_id),
    .add_dropped(add_dropped)
  );

  always #5 clk = ~clk;

  // descending priority, then ascending id
  function automatic bit runs_ahead(entry_t a, entry_t b);
    if ($signed(a.prio) != $signed(b.prio)) return $signed(a.prio) > $signed(b.prio);
    return a.id < b.id;
  endfunction

  function automatic queue_view_t apply_request(job_req_t r);
    queue_view_t v;
    entry_t key;
    int j;
    v.dropped = 1'b0;
    case (r.act)
      ACT_ADD: begin
        if (mirror_count < QDEPTH) begin
          mirror_tab[mirror_count].prio = r.prio;
          mirror_tab[mirror_count].id   = mirror_next_id;
          mirror_count++;
          mirror_next_id++;
        end else begin
          v.dropped = 1'b1;
        end
      end
      ACT_FINISH: begin
        if (mirror_count > 0) begin
          for (int i = 1; i < mirror_count; i++) mirror_tab[i-1] = mirror_tab[i];
          mirror_count--;
        end
      end
      ACT_SORT: begin
        for (int i = 1; i < mirror_count; i++) begin
          key = mirror_tab[i];
          j = i;
          while (j > 0 && runs_ahead(key, mirror_tab[j-1])) begin
            mirror_tab[j] = mirror_tab[j-1];
            j--;
          end
          mirror_tab[j] = key;
        end
      end
      default: mirror_count = 0;
    endcase
    v.count = mirror_count[COUNT_W-1:0];
    v.valid = (mirror_count > 0);
    v.prio  = (mirror_count > 0) ? mirror_tab[0].prio : '0;
    v.id    = (mirror_count > 0) ? mirror_tab[0].id : '0;
    return v;
  endfunction

  task automatic note_failure(string msg);
    if (error_count < 10) $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic push_req(logic [1:0] act, logic signed [PRIO_W-1:0] prio);
    job_req_t r;
    r.act  = act;
    r.prio = prio;
    pending_reqs.push_back(r);
  endtask

  // 0: full range, 1: narrow band for ties, 2: extremes mixed in
  function automatic logic signed [PRIO_W-1:0] pick_prio(int mode);
    int sel;
    sel = $urandom_range(0, 3);
    if (mode == 1) return $signed(PRIO_W'($urandom_range(0, 4))) - 16'sd2;
    if (mode == 2 && sel == 0) return 16'sh7FFF;
    if (mode == 2 && sel == 1) return 16'sh8000;
    return PRIO_W'($urandom);
  endfunction

  task automatic gen_batch(bit force_full);
    int mode;
    int n;
    mode = $urandom_range(0, 2);
    if (force_full || $urandom_range(0, 2) == 0) push_req(ACT_CLEAR, pick_prio(0));
    n = force_full ? QDEPTH + 3 : $urandom_range(1, 20);
    for (int k = 0; k < n; k++) begin
      push_req(ACT_ADD, pick_prio(mode));
      if (!force_full && $urandom_range(0, 9) == 0) push_req(ACT_FINISH, pick_prio(0));
    end
    push_req(ACT_SORT, pick_prio(0));
    n = $urandom_range(0, 6);
    for (int k = 0; k < n; k++) push_req(ACT_FINISH, pick_prio(0));
    if ($urandom_range(0, 1) == 0) begin
      n = $urandom_range(1, 5);
      for (int k = 0; k < n; k++) push_req(ACT_ADD, pick_prio(mode));
      push_req(ACT_SORT, pick_prio(0));
    end
  endtask

  task automatic gen_noise();
    int n;
    n = $urandom_range(1, 8);
    for (int k = 0; k < n; k++) begin
      // clear kept rare so the table rarely gets wiped by noise
      if ($urandom_range(0, 7) == 0) push_req(ACT_CLEAR, pick_prio(0));
      else push_req(2'($urandom_range(0, 2)), pick_prio(0));
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_valid && send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (!in_valid && send_gap > 0) begin
        send_gap--;
      end else if (pending_reqs.size() > 0) begin
        next_req = pending_reqs.pop_front();
        action <= next_req.act;
        priority_req <= next_req.prio;
        in_valid <= 1'b1;
        if (send_calm > 0) begin
          send_calm--;
          send_gap = 0;
        end else begin
          send_gap = $urandom_range(0, 7);
          if ($urandom_range(0, 19) == 0) send_calm = $urandom_range(10, 40);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver back-pressure
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (recv_wait > 0) begin
      out_stall <= 1'b1;
      recv_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: predict on request transfer, check on result transfer
  always @(posedge clk) begin
    if (!rst) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        in_taken <= in_valid && !in_stall;
        if (out_valid && !out_stall) begin
          if (expected_views.size() == 0) begin
            note_failure($sformatf("unexpected result: count %0d front %0d/%0d",
                                   job_count, front_priority, front_id));
          end else begin
            want = expected_views.pop_front();
            if (job_count !== want.count)
              note_failure($sformatf("job_count exp %0d got %0d", want.count, job_count));
            if (front_valid !== want.valid)
              note_failure($sformatf("front_valid exp %0b got %0b", want.valid, front_valid));
            if (front_priority !== want.prio)
              note_failure($sformatf("front_priority exp %0d got %0d",
                                     want.prio, front_priority));
            if (front_id !== want.id)
              note_failure($sformatf("front_id exp %0d got %0d", want.id, front_id));
            if (add_dropped !== want.dropped)
              note_failure($sformatf("add_dropped exp %0b got %0b", want.dropped, add_dropped));
          end
          if (recv_calm > 0) begin
            recv_calm--;
            recv_wait = 0;
          end else begin
            recv_wait = $urandom_range(0, 7);
            if ($urandom_range(0, 19) == 0) recv_calm = $urandom_range(10, 40);
          end
        end
        if (in_valid && !in_stall) begin
          next_req.act  = action;
          next_req.prio = priority_req;
          expected_views.push_back(apply_request(next_req));
        end
      end
    end
  end

  initial begin
    // opening pass: empty-queue requests, extreme priorities, ties, one-job sort
    push_req(ACT_FINISH, 16'sh7FFF);
    push_req(ACT_SORT, 16'sh8000);
    push_req(ACT_CLEAR, 16'shFFFF);
    push_req(ACT_ADD, 16'sh8000);
    push_req(ACT_SORT, 16'sh0000);
    push_req(ACT_ADD, 16'sh7FFF);
    push_req(ACT_ADD, 16'sh0000);
    push_req(ACT_ADD, 16'shFFFF);
    push_req(ACT_ADD, 16'sh7FFF);
    push_req(ACT_ADD, 16'sh5555);
    push_req(ACT_ADD, 16'shAAAA);
    push_req(ACT_SORT, 16'sh5555);
    push_req(ACT_FINISH, 16'shAAAA);
    push_req(ACT_FINISH, 16'sh0000);
    push_req(ACT_CLEAR, 16'sh0000);
    push_req(ACT_ADD, 16'sh0007);
    push_req(ACT_FINISH, 16'sh0000);
    push_req(ACT_FINISH, 16'sh0000);
    // fill past the top so adds get dropped, then sort a full table
    gen_batch(1'b1);
    while (pending_reqs.size() < REQ_TARGET) begin
      if ($urandom_range(0, 3) == 0) gen_noise();
      else gen_batch(1'b0);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (expected_views.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    error_count += expected_views.size();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
